// ----- rtl/core/plw_pkg.sv -----
package plw_pkg;

	// Sample and coefficient formats
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int INDEX_W  = 12;

	// Job queue between the front and back parts
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_COURANT         = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_COURANT_SQUARED = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_point;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] new_value;
		logic [INDEX_W-1:0]         point_index;
		logic                       level_done;
	} out_item_t;

	typedef struct packed {
		logic [COEF_W-1:0] half_courant;
		logic [COEF_W-1:0] half_courant_squared;
	} cfg_regs_t;

	// What one accepted sample asks of the back part
	typedef enum logic [1:0] {
		JOB_SINGLE,   // one-point level: one result
		JOB_PAIR,     // two-point level: two results
		JOB_MID,      // interior point: one result
		JOB_END       // flagged sample of a longer level: three results
	} job_kind_t;

	// Samples seen so far in the current level
	typedef enum logic [1:0] {
		FILL_EMPTY,
		FILL_ONE,
		FILL_MORE
	} fill_t;

	typedef struct packed {
		job_kind_t                  kind;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] older;
		logic signed [SAMPLE_W-1:0] newer;
		logic signed [SAMPLE_W-1:0] first;
		logic signed [SAMPLE_W-1:0] second;
		logic [INDEX_W-1:0]         cur_idx;
		logic [INDEX_W-1:0]         prev_idx;
	} job_entry_t;

endpackage

// ----- rtl/core/plw_front.sv -----
module plw_front import plw_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	input  logic       q_full,
	output logic       q_push,
	output job_entry_t q_entry
);

	localparam int PW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 2;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_POINTS - 1);

	fill_t                      fill_q, fill_next;
	logic signed [SAMPLE_W-1:0] first_q, second_q, older_q, newer_q;
	logic [PW-1:0]              pos_q, pos_inc, pos_dec;
	logic [PW+INDEX_W-1:0]      cur_wide, prev_wide;
	logic                       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Wrap the position at the grid size
	assign pos_inc   = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
	assign pos_dec   = (pos_q == '0) ? POS_LAST : pos_q - 1'b1;
	assign cur_wide  = {{INDEX_W{1'b0}}, pos_q};
	assign prev_wide = {{INDEX_W{1'b0}}, pos_dec};

	// Next fill state
	always_comb begin
		fill_next = fill_q;
		if (accept) begin
			if (in_data.last_point) begin
				fill_next = FILL_EMPTY;
			end else begin
				unique case (fill_q)
					FILL_EMPTY: fill_next = FILL_ONE;
					FILL_ONE:   fill_next = FILL_MORE;
					FILL_MORE:  fill_next = FILL_MORE;
					default:    fill_next = FILL_EMPTY;
				endcase
			end
		end
	end

	// Classify the sample and build the job entry
	always_comb begin
		q_entry.sample   = in_data.sample;
		q_entry.older    = older_q;
		q_entry.newer    = newer_q;
		q_entry.first    = first_q;
		q_entry.second   = second_q;
		q_entry.cur_idx  = cur_wide[INDEX_W-1:0];
		q_entry.prev_idx = prev_wide[INDEX_W-1:0];
		q_entry.kind     = JOB_MID;
		q_push           = 1'b0;
		unique case (fill_q)
			FILL_EMPTY: begin
				q_entry.kind = JOB_SINGLE;
				q_push       = accept && in_data.last_point;
			end
			FILL_ONE: begin
				q_entry.kind = JOB_PAIR;
				q_push       = accept && in_data.last_point;
			end
			FILL_MORE: begin
				q_entry.kind = in_data.last_point ? JOB_END : JOB_MID;
				q_push       = accept;
			end
			default: begin
				q_entry.kind = JOB_MID;
				q_push       = 1'b0;
			end
		endcase
	end

	// Advance the level state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= FILL_EMPTY;
			first_q  <= '0;
			second_q <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			pos_q    <= '0;
		end else begin
			fill_q <= fill_next;
			if (accept) begin
				if (in_data.last_point) begin
					first_q  <= '0;
					second_q <= '0;
					older_q  <= '0;
					newer_q  <= '0;
					pos_q    <= '0;
				end else begin
					pos_q   <= pos_inc;
					newer_q <= in_data.sample;
					if (fill_q == FILL_EMPTY) begin
						first_q <= in_data.sample;
					end else begin
						older_q <= newer_q;
					end
					if (fill_q == FILL_ONE) begin
						second_q <= in_data.sample;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/core/plw_queue.sv -----
module plw_queue import plw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output job_entry_t head
);

	job_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/plw_back.sv -----
module plw_back import plw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_regs_t  cfg,
	input  logic       q_empty,
	input  job_entry_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	localparam int D1_W  = SAMPLE_W + 1;
	localparam int D2_W  = SAMPLE_W + 2;
	localparam int P1_W  = D1_W + COEF_W + 1;
	localparam int P2_W  = D2_W + COEF_W + 1;
	localparam int ACC_W = P2_W + 2;
	localparam int Q_W   = ACC_W - 16;

	logic [1:0]                 job_q;
	logic                       last_job;
	logic signed [SAMPLE_W-1:0] left, centre, right;
	logic [INDEX_W-1:0]         idx;
	logic                       done;
	logic                       issue;

	logic                       valid_s1, valid_s2;
	logic                       s1_ready, s2_ready, out_ready;
	logic signed [D1_W-1:0]     d1_s1;
	logic signed [D2_W-1:0]     d2_s1;
	logic signed [SAMPLE_W-1:0] centre_s1, centre_s2;
	logic [INDEX_W-1:0]         idx_s1, idx_s2;
	logic                       done_s1, done_s2;
	logic signed [P1_W-1:0]     p1_s2;
	logic signed [P2_W-1:0]     p2_s2;

	logic signed [COEF_W:0]     a_ext, b_ext;
	logic signed [ACC_W-1:0]    acc;
	logic signed [Q_W-1:0]      qv;
	logic signed [SAMPLE_W-1:0] sat;

	// Pick the stencil of the current job from the head entry
	always_comb begin
		left     = q_head.older;
		centre   = q_head.newer;
		right    = q_head.sample;
		idx      = q_head.prev_idx;
		done     = 1'b0;
		last_job = 1'b1;
		unique case (q_head.kind)
			JOB_SINGLE: begin
				left   = q_head.sample;
				centre = q_head.sample;
				right  = q_head.sample;
				idx    = '0;
				done   = 1'b1;
			end
			JOB_PAIR: begin
				if (job_q == 2'd0) begin
					left     = q_head.first;
					centre   = q_head.sample;
					right    = q_head.first;
					idx      = q_head.cur_idx;
					last_job = 1'b0;
				end else begin
					left   = q_head.sample;
					centre = q_head.first;
					right  = q_head.sample;
					idx    = '0;
					done   = 1'b1;
				end
			end
			JOB_MID: begin
				last_job = 1'b1;
			end
			JOB_END: begin
				if (job_q == 2'd0) begin
					last_job = 1'b0;
				end else if (job_q == 2'd1) begin
					left     = q_head.newer;
					centre   = q_head.sample;
					right    = q_head.first;
					idx      = q_head.cur_idx;
					last_job = 1'b0;
				end else begin
					left   = q_head.sample;
					centre = q_head.first;
					right  = q_head.second;
					idx    = '0;
					done   = 1'b1;
				end
			end
			default: begin
				last_job = 1'b1;
			end
		endcase
	end

	// Pipeline flow control
	assign out_ready = !out_valid || !out_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign issue     = !q_empty && s1_ready;
	assign q_pop     = issue && last_job;

	// Step through the jobs of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '0;
		end else if (issue) begin
			job_q <= last_job ? 2'd0 : job_q + 2'd1;
		end
	end

	// Valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= issue;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid <= valid_s2;
			end
		end
	end

	// Stage 1: differences
	always_ff @(posedge clk) begin
		if (s1_ready && issue) begin
			d1_s1     <= D1_W'(right) - D1_W'(left);
			d2_s1     <= D2_W'(right) - (D2_W'(centre) <<< 1) + D2_W'(left);
			centre_s1 <= centre;
			idx_s1    <= idx;
			done_s1   <= done;
		end
	end

	// Stage 2: coefficient products
	assign a_ext = {1'b0, cfg.half_courant};
	assign b_ext = {1'b0, cfg.half_courant_squared};

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			p1_s2     <= P1_W'(a_ext) * P1_W'(d1_s1);
			p2_s2     <= P2_W'(b_ext) * P2_W'(d2_s1);
			centre_s2 <= centre_s1;
			idx_s2    <= idx_s1;
			done_s2   <= done_s1;
		end
	end

	// Sum, round half up, saturate
	always_comb begin
		acc = (ACC_W'(centre_s2) <<< 16) - ACC_W'(p1_s2) + ACC_W'(p2_s2)
			+ ACC_W'(32768);
		qv  = acc[ACC_W-1:16];
		if (qv > Q_W'(32767)) begin
			sat = 16'sh7FFF;
		end else if (qv < -Q_W'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = qv[SAMPLE_W-1:0];
		end
	end

	// Output register: hold while stalled
	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			out_data.new_value   <= sat;
			out_data.point_index <= idx_s2;
			out_data.level_done  <= done_s2;
		end
	end

endmodule

// ----- rtl/core/periodic_lax_wendroff_stencil_top.sv -----
// One Lax-Wendroff time level of a periodic grid for linear advection.
// Samples (signed Q1.14) stream in grid order, the final point flagged by
// last_point; each sample from the third on produces the updated value of
// the point before it, and the flagged sample also produces the last point
// and point 0 (level_done marks the final result). A level of one or two
// points gives one or two results. The coefficients half_courant (c/2) and
// half_courant_squared (c*c/2), both unsigned Q0.16, are at index 0 and 1;
// the user must write them only while the block is idle, as the block
// itself does not enforce it. One sample is taken per clock while the job
// queue is not full; a flagged sample occupies the shared stencil datapath
// for up to three jobs, and a four-entry job queue between the sample front
// end and that datapath absorbs it. A result passes from the queue, written
// at the accepting edge, through the differences and products registers,
// then round and saturate into the output register; output stalls hold it.
module periodic_lax_wendroff_stencil_top import plw_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]      cfg_data
);

	cfg_regs_t  cfg_q;
	job_entry_t push_entry, head;
	logic       q_push, q_full, q_pop, q_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_COURANT:         cfg_q.half_courant         <= cfg_data;
				CFG_HALF_COURANT_SQUARED: cfg_q.half_courant_squared <= cfg_data;
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	plw_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (push_entry)
	);

	plw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head)
	);

	plw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
